@@ rtl/font_atlas_glyph_row_addresser_macros.svh @@
// Assertion macros shared by the glyph row addresser modules.
`ifndef FONT_ATLAS_GLYPH_ROW_ADDRESSER_MACROS_SVH
`define FONT_ATLAS_GLYPH_ROW_ADDRESSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FAGRA_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FAGRA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ rtl/fagra_pkg.sv @@
// Types, constants and register codes of the glyph row addresser.
package fagra_pkg;

    localparam int MAX_GLYPH_SIZE = 64;
    localparam int MAX_IMAGE_DIM  = 4096;
    localparam int BPP_SHIFT      = 2;    // four bytes per pixel
    localparam int OFS_W          = 26;
    localparam int PIX_W          = OFS_W - BPP_SHIFT;

    localparam int GS_W    = 7;
    localparam int SP_W    = 8;
    localparam int DIM_W   = 13;
    localparam int FONT_W  = 8;
    localparam int POS_W   = 12;
    localparam int CODE_W  = 8;
    localparam int ROW_W   = 6;
    localparam int PITCH_W = 9;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    localparam logic [CODE_W-1:0] FIRST_DRAWN = 8'h21;
    localparam logic [CODE_W-1:0] LAST_DRAWN  = 8'h7F;

    // Linear glyph pixel index k * glyph_size, divided two bits per step.
    localparam int GLYPH_W   = 7;
    localparam int LIN_W     = 14;
    localparam int DIV_STEPS = LIN_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int QG_W      = LIN_W + GS_W;

    // Job queue between the front and the row emitter (power of two deep).
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLYPH_SIZE    = 4'd0,
        CFG_GLYPH_SPACING = 4'd1,
        CFG_ATLAS_WIDTH   = 4'd2,
        CFG_FONT_SELECT   = 4'd3,
        CFG_IMAGE_WIDTH   = 4'd4,
        CFG_IMAGE_HEIGHT  = 4'd5,
        CFG_ORIGIN_X      = 4'd6,
        CFG_ORIGIN_Y      = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_CHECK,
        FS_TEST,
        FS_DIV,
        FS_MUL,
        FS_PUSH
    } t_front_state;

    // Configuration as seen by the datapath, with oversized glyph size, atlas width and image size clamped.
    typedef struct packed {
        logic [GS_W-1:0]   gs;
        logic [SP_W-1:0]   sp;
        logic [DIM_W-1:0]  aw;
        logic [DIM_W-1:0]  iw;
        logic [DIM_W-1:0]  ih;
        logic [DIM_W-1:0]  ox;
        logic [DIM_W-1:0]  oy;
        logic [FONT_W-1:0] font;
    } t_cfg;

    typedef struct packed {
        logic [OFS_W-1:0] src;
        logic [OFS_W-1:0] dst;
    } t_job;

endpackage

@@ rtl/fagra_cfg.sv @@
// Configuration register file with clamping of oversized glyph size, atlas width and image size.
module fagra_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  logic [fagra_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [fagra_pkg::CFG_DATA_W-1:0] i_data,
    output fagra_pkg::t_cfg                  o_cfg
);
    import fagra_pkg::*;

    logic [GS_W-1:0]   r_gs;
    logic [SP_W-1:0]   r_sp;
    logic [DIM_W-1:0]  r_aw;
    logic [FONT_W-1:0] r_font;
    logic [DIM_W-1:0]  r_iw;
    logic [DIM_W-1:0]  r_ih;
    logic [DIM_W-1:0]  r_ox;
    logic [DIM_W-1:0]  r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs   <= GS_W'(8);
            r_sp   <= '0;
            r_aw   <= DIM_W'(128);
            r_font <= '0;
            r_iw   <= DIM_W'(640);
            r_ih   <= DIM_W'(480);
            r_ox   <= '0;
            r_oy   <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_GLYPH_SIZE:    r_gs   <= i_data[GS_W-1:0];
                CFG_GLYPH_SPACING: r_sp   <= i_data[SP_W-1:0];
                CFG_ATLAS_WIDTH:   r_aw   <= i_data[DIM_W-1:0];
                CFG_FONT_SELECT:   r_font <= i_data[FONT_W-1:0];
                CFG_IMAGE_WIDTH:   r_iw   <= i_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT:  r_ih   <= i_data[DIM_W-1:0];
                CFG_ORIGIN_X:      r_ox   <= i_data[DIM_W-1:0];
                CFG_ORIGIN_Y:      r_oy   <= i_data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.gs   = (r_gs > GS_W'(MAX_GLYPH_SIZE)) ? GS_W'(MAX_GLYPH_SIZE) : r_gs;
        o_cfg.sp   = r_sp;
        o_cfg.aw   = (r_aw > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : r_aw;
        o_cfg.iw   = (r_iw > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : r_iw;
        o_cfg.ih   = (r_ih > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : r_ih;
        o_cfg.ox   = r_ox;
        o_cfg.oy   = r_oy;
        o_cfg.font = r_font;
    end

endmodule

@@ rtl/fagra_front.sv @@
// Front end: accepts a character, filters it and computes the glyph base offsets.
module fagra_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fagra_pkg::t_cfg               i_cfg,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [fagra_pkg::POS_W-1:0]   i_position,
    input  logic [fagra_pkg::CODE_W-1:0]  i_char_code,
    input  logic                          i_past_end,
    output logic                          o_q_push,
    output fagra_pkg::t_job               o_q_data,
    input  logic                          i_q_full
);
    import fagra_pkg::*;
    `include "font_atlas_glyph_row_addresser_macros.svh"

    t_front_state r_state, n_state;

    logic [POS_W-1:0]         r_pos;
    logic [CODE_W-1:0]        r_code;
    logic [POS_W+PITCH_W-1:0] r_pp;
    logic [OFS_W-1:0]         r_oyiw;
    logic [LIN_W-1:0]         r_lin;
    logic                     r_ok;
    logic [LIN_W-1:0]         r_dq;
    logic [DIM_W-1:0]         r_rem;
    logic [DCNT_W-1:0]        r_dcnt;
    logic [QG_W-1:0]          r_qg;
    logic [OFS_W-1:0]         r_dst;

    logic [PITCH_W-1:0]       w_pitch;
    logic [GLYPH_W-1:0]       w_glyph;
    logic                     w_draw;
    logic [LIN_W-1:0]         w_dq;
    logic [DIM_W-1:0]         w_rem;
    logic [PIX_W-1:0]         w_dst_pix;
    logic [PIX_W-1:0]         w_src_pix;

    assign w_pitch = PITCH_W'(i_cfg.gs) + PITCH_W'(i_cfg.sp);
    assign w_glyph = GLYPH_W'(r_code - FIRST_DRAWN);

    // The cell fits when (position + 1) * pitch stays within the image width.
    assign w_draw = r_ok &&
        ((POS_W+PITCH_W+1)'(r_pp) + (POS_W+PITCH_W+1)'(w_pitch)
         <= (POS_W+PITCH_W+1)'(i_cfg.iw));

    // Two restoring division steps per cycle.
    always_comb begin
        logic [DIM_W:0] rem_ext;
        w_dq  = r_dq;
        w_rem = r_rem;
        for (int j = 0; j < 2; j++) begin
            rem_ext = {w_rem, w_dq[LIN_W-1]};
            w_dq    = {w_dq[LIN_W-2:0], 1'b0};
            if (rem_ext >= (DIM_W+1)'(i_cfg.aw)) begin
                w_rem   = DIM_W'(rem_ext - (DIM_W+1)'(i_cfg.aw));
                w_dq[0] = 1'b1;
            end else begin
                w_rem = rem_ext[DIM_W-1:0];
            end
        end
    end

    assign w_dst_pix = PIX_W'(r_oyiw) + PIX_W'(i_cfg.ox) + PIX_W'(r_pp);
    assign w_src_pix = PIX_W'(PIX_W'(r_qg) * PIX_W'(i_cfg.aw)) + PIX_W'(r_rem);

    assign o_q_data.src = {w_src_pix, BPP_SHIFT'(0)};
    assign o_q_data.dst = r_dst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_full   = 1'b1;
        o_q_push = 1'b0;
        unique case (r_state)
            FS_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = FS_CHECK;
                end
            end
            FS_CHECK: begin
                n_state = FS_TEST;
            end
            FS_TEST: begin
                n_state = w_draw ? FS_DIV : FS_IDLE;
            end
            FS_DIV: begin
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                o_q_push = !i_q_full;
                if (!i_q_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            FS_IDLE: begin
                r_pos  <= i_position;
                r_code <= i_past_end ? LAST_DRAWN : i_char_code;
            end
            FS_CHECK: begin
                r_pp   <= (POS_W+PITCH_W)'(r_pos) * (POS_W+PITCH_W)'(w_pitch);
                r_oyiw <= OFS_W'(i_cfg.oy) * OFS_W'(i_cfg.iw);
                r_lin  <= LIN_W'(w_glyph) * LIN_W'(i_cfg.gs);
                r_ok   <= (i_cfg.gs != '0) && (i_cfg.aw != '0) &&
                          (i_cfg.ox <= i_cfg.iw) && (i_cfg.oy <= i_cfg.ih) &&
                          (r_code >= FIRST_DRAWN) && (r_code <= LAST_DRAWN);
            end
            FS_TEST: begin
                r_dq   <= r_lin;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            FS_DIV: begin
                r_dq   <= w_dq;
                r_rem  <= w_rem;
                r_dcnt <= r_dcnt + DCNT_W'(1);
            end
            FS_MUL: begin
                r_qg  <= QG_W'(r_dq) * QG_W'(i_cfg.gs);
                r_dst <= {w_dst_pix, BPP_SHIFT'(0)};
            end
            default: begin
            end
        endcase
    end

    `FAGRA_ASSERT_NOW(a_div_count, i_clk, i_rst_n, r_state == FS_DIV, r_dcnt < DCNT_W'(DIV_STEPS), "divider step count out of range")
    `FAGRA_ASSERT_NEXT(a_push_done, i_clk, i_rst_n, o_q_push, r_state == FS_IDLE, "front did not return to idle after queueing a job")

endmodule

@@ rtl/fagra_queue.sv @@
// Small job queue between the front end and the row emitter.
module fagra_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  fagra_pkg::t_job i_data,
    output logic            o_full,
    input  logic            i_pop,
    output fagra_pkg::t_job o_data,
    output logic            o_empty
);
    import fagra_pkg::*;
    `include "font_atlas_glyph_row_addresser_macros.svh"

    t_job              r_mem [Q_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              w_wr;
    logic              w_rd;

    assign o_full  = (r_count == QCNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (w_rd) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `FAGRA_ASSERT_NOW(a_q_count, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(Q_DEPTH), "queue count exceeds depth")

endmodule

@@ rtl/fagra_back.sv @@
// Row emitter: steps through the rows of one glyph, one result word per row.
module fagra_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fagra_pkg::t_cfg               i_cfg,
    input  fagra_pkg::t_job               i_q_data,
    input  logic                          i_q_empty,
    output logic                          o_q_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [fagra_pkg::OFS_W-1:0]   o_atlas_offset,
    output logic [fagra_pkg::OFS_W-1:0]   o_dest_offset,
    output logic [fagra_pkg::ROW_W-1:0]   o_row_index,
    output logic                          o_last_row
);
    import fagra_pkg::*;
    `include "font_atlas_glyph_row_addresser_macros.svh"

    logic             r_busy;
    logic [ROW_W-1:0] r_row;
    logic [OFS_W-1:0] r_a;
    logic [OFS_W-1:0] r_d;

    logic             w_last;
    logic             w_pop;
    logic             w_load;

    assign w_last = ((GS_W'(r_row) + GS_W'(1)) == i_cfg.gs);
    assign w_pop  = i_pop && r_busy;
    assign w_load = (!r_busy || (w_pop && w_last)) && !i_q_empty;

    assign o_q_pop        = w_load;
    assign o_empty        = !r_busy;
    assign o_atlas_offset = r_a;
    assign o_dest_offset  = r_d;
    assign o_row_index    = r_row;
    assign o_last_row     = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (w_pop && w_last) begin
            r_busy <= 1'b0;
        end
    end

    // Each further row moves both offsets down by one row of their image.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_row <= '0;
            r_a   <= i_q_data.src;
            r_d   <= i_q_data.dst;
        end else if (w_pop) begin
            r_row <= r_row + ROW_W'(1);
            r_a   <= r_a + (OFS_W'(i_cfg.aw) << BPP_SHIFT);
            r_d   <= r_d + (OFS_W'(i_cfg.iw) << BPP_SHIFT);
        end
    end

    `FAGRA_ASSERT_NEXT(a_row_step, i_clk, i_rst_n, w_pop && !w_last, r_busy && (r_row == $past(r_row) + ROW_W'(1)), "row counter did not advance")

endmodule

@@ rtl/font_atlas_glyph_row_addresser.sv @@
// A drawn character passes the check, test, divide, multiply and push states and the queue
// before its first row shows. The front end takes a new character only once done with
// the last, held by its radix-4 divider; a skipped character leaves at the test state.
// The row emitter gives one row word per cycle while pop is high, glyph_size per glyph.
// Reset (synchronous, active low) restores the register defaults and empties the queue.
module font_atlas_glyph_row_addresser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             valid,
    output logic                             ready,
    input  logic [fagra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fagra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             push,
    output logic                             full,
    input  logic [fagra_pkg::POS_W-1:0]      i_position,
    input  logic [fagra_pkg::CODE_W-1:0]     i_char_code,
    input  logic                             i_past_end,
    output logic                             empty,
    input  logic                             pop,
    output logic [fagra_pkg::OFS_W-1:0]      o_atlas_offset,
    output logic [fagra_pkg::OFS_W-1:0]      o_dest_offset,
    output logic [fagra_pkg::ROW_W-1:0]      o_row_index,
    output logic                             o_last_row
);
    import fagra_pkg::*;

    t_cfg w_cfg;
    t_job w_push_data;
    t_job w_pop_data;
    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_empty;

    assign ready = 1'b1;

    fagra_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    fagra_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_position  (i_position),
        .i_char_code (i_char_code),
        .i_past_end  (i_past_end),
        .o_q_push    (w_q_push),
        .o_q_data    (w_push_data),
        .i_q_full    (w_q_full)
    );

    fagra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_push_data),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_pop_data),
        .o_empty (w_q_empty)
    );

    fagra_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_q_data       (w_pop_data),
        .i_q_empty      (w_q_empty),
        .o_q_pop        (w_q_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_atlas_offset (o_atlas_offset),
        .o_dest_offset  (o_dest_offset),
        .o_row_index    (o_row_index),
        .o_last_row     (o_last_row)
    );

endmodule

@@ sim/tb_font_atlas_glyph_row_addresser.sv @@
// Self-checking testbench for the glyph row addresser: directed and random characters, scoreboard.
`timescale 1ns / 100ps

import fagra_pkg::*;

typedef struct packed {
    logic [OFS_W-1:0] atlas;
    logic [OFS_W-1:0] dest;
    logic [ROW_W-1:0] row;
    logic             last;
} t_glyph_row;

class glyph_row_scoreboard;
    bit [GS_W-1:0]   glyph_size;
    bit [SP_W-1:0]   glyph_spacing;
    bit [DIM_W-1:0]  atlas_width;
    bit [FONT_W-1:0] font_select;
    bit [DIM_W-1:0]  image_width;
    bit [DIM_W-1:0]  image_height;
    bit [DIM_W-1:0]  origin_x;
    bit [DIM_W-1:0]  origin_y;
    t_glyph_row      rows_due[$];
    int              errors;

    function new();
        glyph_size    = 8;
        glyph_spacing = 0;
        atlas_width   = 128;
        font_select   = 0;
        image_width   = 640;
        image_height  = 480;
        origin_x      = 0;
        origin_y      = 0;
        errors        = 0;
    endfunction

    function bit [63:0] clamp(bit [63:0] v, bit [63:0] lim);
        return (v > lim) ? lim : v;
    endfunction

    function int pending();
        return rows_due.size();
    endfunction

    // Each register keeps only as many low data bits as it is wide.
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GLYPH_SIZE:    glyph_size    = data[GS_W-1:0];
            CFG_GLYPH_SPACING: glyph_spacing = data[SP_W-1:0];
            CFG_ATLAS_WIDTH:   atlas_width   = data;
            CFG_FONT_SELECT:   font_select   = data[FONT_W-1:0];
            CFG_IMAGE_WIDTH:   image_width   = data;
            CFG_IMAGE_HEIGHT:  image_height  = data;
            CFG_ORIGIN_X:      origin_x      = data;
            CFG_ORIGIN_Y:      origin_y      = data;
            default: ;
        endcase
    endfunction

    // Number of cell positions that can be drawn under the current settings.
    function int drawn_cells();
        bit [63:0] gs, aw, iw, ih;
        gs = clamp(64'(glyph_size), 64'(MAX_GLYPH_SIZE));
        aw = clamp(64'(atlas_width), 64'(MAX_IMAGE_DIM));
        iw = clamp(64'(image_width), 64'(MAX_IMAGE_DIM));
        ih = clamp(64'(image_height), 64'(MAX_IMAGE_DIM));
        if (gs == 0 || aw == 0 || 64'(origin_x) > iw || 64'(origin_y) > ih)
            return 0;
        return int'(iw / (gs + 64'(glyph_spacing)));
    endfunction

    function void note_char(logic [POS_W-1:0] pos, logic [CODE_W-1:0] code_in, logic past_end);
        bit [63:0]  gs, aw, iw, ih, pitch, code, lin, src, dst, r;
        t_glyph_row w;
        code = past_end ? 64'(LAST_DRAWN) : 64'(code_in);
        gs = clamp(64'(glyph_size), 64'(MAX_GLYPH_SIZE));
        aw = clamp(64'(atlas_width), 64'(MAX_IMAGE_DIM));
        iw = clamp(64'(image_width), 64'(MAX_IMAGE_DIM));
        ih = clamp(64'(image_height), 64'(MAX_IMAGE_DIM));
        if (gs == 0 || aw == 0)
            return;
        if (64'(origin_x) > iw || 64'(origin_y) > ih)
            return;
        pitch = gs + 64'(glyph_spacing);
        if (64'(pos) >= iw / pitch)
            return;
        if (code < 64'(FIRST_DRAWN) || code > 64'(LAST_DRAWN))
            return;
        // Glyphs sit side by side in linear pixel order, folded into atlas rows.
        lin = (code - 64'(FIRST_DRAWN)) * gs;
        src = ((lin / aw) * gs * aw + lin % aw) << BPP_SHIFT;
        dst = (64'(origin_y) * iw + 64'(origin_x) + 64'(pos) * pitch) << BPP_SHIFT;
        for (r = 0; r < gs; r++) begin
            w.atlas = OFS_W'(src + ((r * aw) << BPP_SHIFT));
            w.dest  = OFS_W'(dst + ((r * iw) << BPP_SHIFT));
            w.row   = ROW_W'(r);
            w.last  = (r + 1 == gs);
            rows_due.push_back(w);
        end
    endfunction

    function void flag(string msg);
        errors++;
        if (errors <= 10)
            $display("mismatch: %s", msg);
    endfunction

    function void check_row(logic [OFS_W-1:0] a, logic [OFS_W-1:0] d,
                            logic [ROW_W-1:0] r, logic l);
        t_glyph_row want;
        if (rows_due.size() == 0) begin
            flag($sformatf("unexpected row word atlas=%0h dest=%0h row=%0d last=%0b",
                           a, d, r, l));
            return;
        end
        want = rows_due.pop_front();
        if (want.atlas !== a || want.dest !== d || want.row !== r || want.last !== l)
            flag($sformatf(
                "expected a=%0h d=%0h row=%0d last=%0b, got a=%0h d=%0h row=%0d last=%0b",
                want.atlas, want.dest, want.row, want.last, a, d, r, l));
    endfunction
endclass

module tb_font_atlas_glyph_row_addresser;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int NUM_REGS      = 8;
    localparam int PHASES        = 10;
    localparam int PHASE_CHARS   = 43;

    localparam int RX_STREAM   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  valid = 1'b0;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [POS_W-1:0]      i_position = '0;
    logic [CODE_W-1:0]     i_char_code = '0;
    logic                  i_past_end = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [OFS_W-1:0]      o_atlas_offset;
    logic [OFS_W-1:0]      o_dest_offset;
    logic [ROW_W-1:0]      o_row_index;
    logic                  o_last_row;

    glyph_row_scoreboard sb = new();

    int burst_left = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;
    int rx_cycle = 0;
    int rx_mode = RX_STREAM;
    int cycle_count = 0;

    font_atlas_glyph_row_addresser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .valid          (valid),
        .ready          (ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_position     (i_position),
        .i_char_code    (i_char_code),
        .i_past_end     (i_past_end),
        .empty          (empty),
        .pop            (pop),
        .o_atlas_offset (o_atlas_offset),
        .o_dest_offset  (o_dest_offset),
        .o_row_index    (o_row_index),
        .o_last_row     (o_last_row)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[font_atlas_glyph_row_addresser] ERROR");
            $finish;
        end
    end

    // Row receiver: its cycle counter redraws the stall pattern at random so that gaps drift
    // across the glyph; a requested hold-off blocks it for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                sb.check_row(o_atlas_offset, o_dest_offset, o_row_index, o_last_row);
            rx_cycle++;
            if (rx_cycle % 97 == 0)
                rx_mode = $urandom_range(RX_STREAM, RX_PERIODIC);
            if (holds_served != holds_asked) begin
                holds_served = holds_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STREAM:   pop <= 1'b1;
                    RX_RANDOM:   pop <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   pop <= (rx_cycle % 4 == 0);
                    default:     pop <= (rx_cycle % 5 != 0);
                endcase
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        valid       <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!ready) @(posedge i_clk);
        sb.apply_reg(idx, data);
        valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_char(input logic [POS_W-1:0] pos, input logic [CODE_W-1:0] code,
                             input logic past_end);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push        <= 1'b1;
        i_position  <= pos;
        i_char_code <= code;
        i_past_end  <= past_end;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_char(pos, code, past_end);
    endtask

    // Stop sending, wait for every outstanding row word, then let the block go idle.
    task automatic settle(input int extra);
        push <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] gs, sp, aw, iw, ih, ox, oy;
        int unsigned sel, iw_cap, ih_cap;
        sel = $urandom_range(0, 9);
        gs = (sel < 6) ? CFG_DATA_W'($urandom_range(1, 12))
           : (sel < 9) ? CFG_DATA_W'($urandom_range(1, 64))
                       : CFG_DATA_W'($urandom_range(0, 8191));
        sel = $urandom_range(0, 9);
        sp = (sel < 7) ? CFG_DATA_W'($urandom_range(0, 4))
           : (sel < 9) ? CFG_DATA_W'($urandom_range(0, 255))
                       : CFG_DATA_W'($urandom_range(0, 8191));
        sel = $urandom_range(0, 9);
        aw = (sel < 7) ? CFG_DATA_W'($urandom_range(1, 4096))
           : (sel < 9) ? CFG_DATA_W'($urandom_range(1, 256))
                       : CFG_DATA_W'($urandom_range(0, 8191));
        sel = $urandom_range(0, 9);
        iw = (sel < 8) ? CFG_DATA_W'($urandom_range(256, 4096))
           : (sel < 9) ? CFG_DATA_W'($urandom_range(1, 4096))
                       : CFG_DATA_W'($urandom_range(0, 8191));
        sel = $urandom_range(0, 9);
        ih = (sel < 8) ? CFG_DATA_W'($urandom_range(256, 4096))
           : (sel < 9) ? CFG_DATA_W'($urandom_range(1, 4096))
                       : CFG_DATA_W'($urandom_range(0, 8191));
        iw_cap = (32'(iw) > 32'(MAX_IMAGE_DIM)) ? 32'(MAX_IMAGE_DIM) : 32'(iw);
        ih_cap = (32'(ih) > 32'(MAX_IMAGE_DIM)) ? 32'(MAX_IMAGE_DIM) : 32'(ih);
        ox = ($urandom_range(0, 9) < 9) ? CFG_DATA_W'($urandom_range(0, iw_cap))
                                        : CFG_DATA_W'($urandom_range(0, 8191));
        oy = ($urandom_range(0, 9) < 9) ? CFG_DATA_W'($urandom_range(0, ih_cap))
                                        : CFG_DATA_W'($urandom_range(0, 8191));
        write_reg(CFG_GLYPH_SIZE, gs);
        write_reg(CFG_GLYPH_SPACING, sp);
        write_reg(CFG_ATLAS_WIDTH, aw);
        write_reg(CFG_FONT_SELECT, CFG_DATA_W'($urandom_range(0, 8191)));
        write_reg(CFG_IMAGE_WIDTH, iw);
        write_reg(CFG_IMAGE_HEIGHT, ih);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1)),
                      CFG_DATA_W'($urandom_range(0, 8191)));
    endtask

    task automatic random_char();
        int cells;
        logic [POS_W-1:0]  pos;
        logic [CODE_W-1:0] code;
        cells = sb.drawn_cells();
        if (cells > 0 && $urandom_range(0, 9) < 8)
            pos = POS_W'($urandom_range(0, ((cells > 4096) ? 4096 : cells) - 1));
        else
            pos = POS_W'($urandom);
        code = ($urandom_range(0, 9) < 7) ? CODE_W'($urandom_range(FIRST_DRAWN, LAST_DRAWN))
                                          : CODE_W'($urandom);
        send_char(pos, code, $urandom_range(0, 9) == 0);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: range ends, skipped bytes and the past-end substitute.
        send_char(0, FIRST_DRAWN, 1'b0);
        send_char(79, LAST_DRAWN, 1'b0);
        send_char(80, 8'h41, 1'b0);
        send_char(3, 8'h20, 1'b0);
        send_char(5, 8'h80, 1'b0);
        send_char(6, 8'hFF, 1'b0);
        send_char(7, 8'h00, 1'b1);
        send_char(4095, 8'hFF, 1'b1);
        settle(SETTLE_CYCLES);

        // Oversized values clamp; an origin equal to the image size still draws,
        // and the destination offsets wrap.
        write_reg(CFG_GLYPH_SIZE, 13'h1FFF);
        write_reg(CFG_GLYPH_SPACING, 255);
        write_reg(CFG_ATLAS_WIDTH, 13'h1FFF);
        write_reg(CFG_FONT_SELECT, 255);
        write_reg(CFG_IMAGE_WIDTH, 13'h1FFF);
        write_reg(CFG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(CFG_ORIGIN_X, 4096);
        write_reg(CFG_ORIGIN_Y, 4096);
        send_char(11, LAST_DRAWN, 1'b0);
        send_char(0, 8'h5A, 1'b0);
        send_char(12, 8'h30, 1'b0);
        settle(SETTLE_CYCLES);

        // Smallest glyph and atlas; every position along a full-width line fits.
        write_reg(CFG_GLYPH_SIZE, 1);
        write_reg(CFG_GLYPH_SPACING, 0);
        write_reg(CFG_ATLAS_WIDTH, 1);
        write_reg(CFG_FONT_SELECT, 0);
        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_IMAGE_HEIGHT, 1);
        write_reg(CFG_ORIGIN_X, 0);
        write_reg(CFG_ORIGIN_Y, 1);
        send_char(4095, LAST_DRAWN, 1'b0);
        send_char(2048, 8'h55, 1'b0);
        settle(SETTLE_CYCLES);

        // Origin outside the image in either direction.
        write_reg(CFG_ORIGIN_X, 13'h1FFF);
        send_char(0, FIRST_DRAWN, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(CFG_ORIGIN_X, 0);
        write_reg(CFG_ORIGIN_Y, 2);
        send_char(0, FIRST_DRAWN, 1'b0);
        settle(SETTLE_CYCLES);

        // Zero glyph size, zero atlas width and zero image width draw nothing.
        write_reg(CFG_ORIGIN_Y, 0);
        write_reg(CFG_GLYPH_SIZE, 0);
        send_char(1, 8'h42, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(CFG_GLYPH_SIZE, 8);
        write_reg(CFG_ATLAS_WIDTH, 0);
        send_char(1, 8'h42, 1'b0);
        settle(SETTLE_CYCLES);
        write_reg(CFG_ATLAS_WIDTH, 128);
        write_reg(CFG_IMAGE_WIDTH, 0);
        send_char(0, 8'h42, 1'b0);
        settle(SETTLE_CYCLES);

        // Writes to indexes past the register list must change nothing.
        write_reg(CFG_IMAGE_WIDTH, 640);
        for (int i = NUM_REGS; i < 2**CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 13'h1555 ^ 13'(i));
        send_char(9, 8'h61, 1'b0);
        settle(SETTLE_CYCLES);

        // Largest glyph from an atlas whose width is not a power of two.
        write_reg(CFG_GLYPH_SIZE, 64);
        write_reg(CFG_ATLAS_WIDTH, 100);
        write_reg(CFG_IMAGE_WIDTH, 4096);
        write_reg(CFG_IMAGE_HEIGHT, 4096);
        send_char(63, LAST_DRAWN, 1'b0);
        send_char(62, 8'h7E, 1'b0);

        for (int phase = 0; phase < PHASES; phase++) begin
            settle(SETTLE_CYCLES);
            random_config();
            // One phase runs against a long receiver hold-off so the input backs up.
            // It uses the default geometry so that most characters are drawn.
            if (phase == 3) begin
                write_reg(CFG_GLYPH_SIZE, 8);
                write_reg(CFG_GLYPH_SPACING, 0);
                write_reg(CFG_ATLAS_WIDTH, 128);
                write_reg(CFG_IMAGE_WIDTH, 640);
                write_reg(CFG_IMAGE_HEIGHT, 480);
                write_reg(CFG_ORIGIN_X, 0);
                write_reg(CFG_ORIGIN_Y, 0);
                holds_asked++;
            end
            for (int n = 0; n < PHASE_CHARS; n++) begin
                if (phase == 6 && n == PHASE_CHARS / 2)
                    settle(0);
                random_char();
            end
        end

        settle(SETTLE_CYCLES);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[font_atlas_glyph_row_addresser] OK");
        else
            $display("[font_atlas_glyph_row_addresser] ERROR");
        $finish;
    end

endmodule
